// ===== hw/rtl/mbqbp_pkg.sv =====
// Shared types, constants and the sequencer control store for the band-pass filter.
// Used by mbqbp_mac and multichannel_biquad_bandpass; depends on nothing.
`default_nettype none

package mbqbp_pkg;

   localparam int COEF_W       = 32;
   localparam int COEF_SHIFT   = 30;
   localparam int CH_FIELD_W   = 4;
   localparam int CSR_IDX_W    = 3;
   localparam int HIST_ENTRIES = 8;
   localparam int PC_W         = 4;

   localparam logic [PC_W-1:0] IDLE_STEP  = PC_W'(0);
   localparam logic [PC_W-1:0] FINAL_STEP = PC_W'(15);

   localparam logic signed [COEF_W-1:0] HP_B0_RESET =  32'sd1025181850;
   localparam logic signed [COEF_W-1:0] HP_A1_RESET =  32'sd2048165751;
   localparam logic signed [COEF_W-1:0] HP_A2_RESET = -32'sd978816604;
   localparam logic signed [COEF_W-1:0] LP_B0_RESET =  32'sd166484744;
   localparam logic signed [COEF_W-1:0] LP_A1_RESET =  32'sd665938974;
   localparam logic signed [COEF_W-1:0] LP_A2_RESET = -32'sd258136125;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HP_B0  = 3'd0,
      CSR_HP_A1  = 3'd1,
      CSR_HP_A2  = 3'd2,
      CSR_LP_B0  = 3'd3,
      CSR_LP_A1  = 3'd4,
      CSR_LP_A2  = 3'd5,
      CSR_ENABLE = 3'd6
   } csr_idx_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_ADD2,
      ACC_SUB2
   } acc_op_type;

   typedef enum logic [3:0] {
      OPD_SAMPLE,
      OPD_MID,
      OPD_H0,
      OPD_H1,
      OPD_H2,
      OPD_H3,
      OPD_H4,
      OPD_H5,
      OPD_H6,
      OPD_H7
   } opd_type;

   typedef enum logic [2:0] {
      CF_HP_B0,
      CF_HP_A1,
      CF_HP_A2,
      CF_LP_B0,
      CF_LP_A1,
      CF_LP_A2
   } coef_type;

   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_ACCEPT,
      SEQ_EMIT
   } seq_type;

   typedef struct packed {
      logic       mul_en;
      acc_op_type acc_op;
   } mac_ctrl_type;

   typedef struct packed {
      seq_type         seq;
      logic [PC_W-1:0] jmp;
      opd_type         opd;
      coef_type        coef;
      mac_ctrl_type    mac;
      logic            mem_rd;
      logic            mid_ld;
   } ucode_type;

   // Step program: 0 waits for a request, 1 reads the channel row, 2..7 run the
   // high-pass stage, 8 latches its output, 9..14 run the low-pass stage,
   // 15 writes back the row and hands over the response.
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      w.seq        = SEQ_NEXT;
      w.jmp        = IDLE_STEP;
      w.opd        = OPD_SAMPLE;
      w.coef       = CF_HP_B0;
      w.mac.mul_en = 1'b0;
      w.mac.acc_op = ACC_HOLD;
      w.mem_rd     = 1'b0;
      w.mid_ld     = 1'b0;
      unique case (pc)
         4'd0: begin
            w.seq = SEQ_ACCEPT;
            w.jmp = FINAL_STEP;
         end
         4'd1: begin
            w.mem_rd = 1'b1;
         end
         4'd2: begin
            w.coef = CF_HP_B0; w.opd = OPD_SAMPLE; w.mac.mul_en = 1'b1;
         end
         4'd3: begin
            w.coef = CF_HP_B0; w.opd = OPD_H0; w.mac.mul_en = 1'b1;
            w.mac.acc_op = ACC_LOAD;
         end
         4'd4: begin
            w.coef = CF_HP_B0; w.opd = OPD_H1; w.mac.mul_en = 1'b1;
            w.mac.acc_op = ACC_SUB2;
         end
         4'd5: begin
            w.coef = CF_HP_A1; w.opd = OPD_H2; w.mac.mul_en = 1'b1;
            w.mac.acc_op = ACC_ADD;
         end
         4'd6: begin
            w.coef = CF_HP_A2; w.opd = OPD_H3; w.mac.mul_en = 1'b1;
            w.mac.acc_op = ACC_ADD;
         end
         4'd7: begin
            w.mac.acc_op = ACC_ADD;
         end
         4'd8: begin
            w.mid_ld = 1'b1;
         end
         4'd9: begin
            w.coef = CF_LP_B0; w.opd = OPD_MID; w.mac.mul_en = 1'b1;
         end
         4'd10: begin
            w.coef = CF_LP_B0; w.opd = OPD_H4; w.mac.mul_en = 1'b1;
            w.mac.acc_op = ACC_LOAD;
         end
         4'd11: begin
            w.coef = CF_LP_B0; w.opd = OPD_H5; w.mac.mul_en = 1'b1;
            w.mac.acc_op = ACC_ADD2;
         end
         4'd12: begin
            w.coef = CF_LP_A1; w.opd = OPD_H6; w.mac.mul_en = 1'b1;
            w.mac.acc_op = ACC_ADD;
         end
         4'd13: begin
            w.coef = CF_LP_A2; w.opd = OPD_H7; w.mac.mul_en = 1'b1;
            w.mac.acc_op = ACC_ADD;
         end
         4'd14: begin
            w.mac.acc_op = ACC_ADD;
         end
         4'd15: begin
            w.seq = SEQ_EMIT;
            w.jmp = IDLE_STEP;
         end
         default: begin
            w.seq = SEQ_ACCEPT;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mbqbp_mac.sv =====
// Shared multiply-accumulate unit: registered coefficient x sample product,
// wide accumulator, floor shift by COEF_SHIFT and saturation. Uses mbqbp_pkg.
`default_nettype none

module mbqbp_mac
   import mbqbp_pkg::*;
#(
   parameter int SAMPLE_BITS = 24
) (
   input  wire logic                          clock,
   input  wire mac_ctrl_type                  ctrl,
   input  wire logic signed [COEF_W-1:0]      coef,
   input  wire logic signed [SAMPLE_BITS-1:0] operand,
   output logic signed [SAMPLE_BITS-1:0]      sat_out
);

   localparam int PROD_W = COEF_W + SAMPLE_BITS;
   localparam int ACC_W  = PROD_W + 3;

   localparam logic signed [ACC_W-1:0] SAT_HI =
      ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  prod_ext;
   logic signed [ACC_W-1:0]  prod_dbl;
   logic signed [ACC_W-1:0]  shifted;

   assign prod_ext = ACC_W'(prod_ff);
   assign prod_dbl = prod_ext <<< 1;

   always_comb begin
      unique case (ctrl.acc_op)
         ACC_LOAD: acc_in = prod_ext;
         ACC_ADD:  acc_in = acc_ff + prod_ext;
         ACC_ADD2: acc_in = acc_ff + prod_dbl;
         ACC_SUB2: acc_in = acc_ff - prod_dbl;
         default:  acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= coef * operand;
      end
      acc_ff <= acc_in;
   end

   assign shifted = acc_ff >>> COEF_SHIFT;

   always_comb begin
      if (shifted > SAT_HI) begin
         sat_out = SAT_HI[SAMPLE_BITS-1:0];
      end else if (shifted < SAT_LO) begin
         sat_out = SAT_LO[SAMPLE_BITS-1:0];
      end else begin
         sat_out = shifted[SAMPLE_BITS-1:0];
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/multichannel_biquad_bandpass.sv =====
// Top level of the multichannel band-pass filter: step sequencer, history memory,
// coefficient registers and stream ports. Uses mbqbp_pkg and mbqbp_mac.
// Usage:
//   req_* carries one request per sample: tdata = sample, tuser = channel,
//   tlast = end-of-buffer marker. rsp_* returns one response per request in
//   order, with channel and tlast copied. csr_* writes coefficient and enable
//   registers, always ready; the user must write it only while idle (unenforced).
//   Any write to a listed register clears the history of every channel.
// Timing:
//   A filtered request passes a row read, ten products on the shared multiplier
//   with a drain per stage, a high-pass latch step and a write-back step on its
//   way to the response register. The next request can be taken the cycle after
//   the response loads, so no new request is accepted until the last is handed
//   over. A bypassed request (enable low or channel at or beyond CHAN_COUNT)
//   jumps from the idle step straight to the final step.
// Reset and stall:
//   Reset restores the 500 Hz / 8000 Hz coefficients, clears enable and marks
//   every channel row empty (reads as zero); no clearing pass is needed.
//   While rsp is stalled the response holds; one further request is accepted
//   and computed, then the sequencer waits in its final step.
`default_nettype none

module multichannel_biquad_bandpass
   import mbqbp_pkg::*;
#(
   parameter int CHAN_COUNT  = 16,
   parameter int SAMPLE_BITS = 24
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     req_tdata,  // [SB-1:0] sample_in
   input  wire logic [CH_FIELD_W-1:0]                req_tuser,  // [3:0] channel
   input  wire logic                                 req_tlast,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]          rsp_tdata,  // [SB-1:0] sample_out
   output logic [CH_FIELD_W-1:0]                     rsp_tuser,  // [3:0] channel_out
   output logic                                      rsp_tlast,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0]                 csr_index,
   input  wire logic [COEF_W-1:0]                    csr_data
);

   localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int CH_W    = (CHAN_COUNT > 1) ? $clog2(CHAN_COUNT) : 1;
   localparam int ROW_W   = HIST_ENTRIES * SAMPLE_BITS;

   logic signed [COEF_W-1:0] hp_b0_ff, hp_a1_ff, hp_a2_ff;
   logic signed [COEF_W-1:0] lp_b0_ff, lp_a1_ff, lp_a2_ff;
   logic                     enable_ff;

   logic [PC_W-1:0]   pc_ff, pc_in;
   ucode_type         uc;

   logic [CH_FIELD_W-1:0]         ch_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic signed [SAMPLE_BITS-1:0] mid_ff;
   logic                          last_ff;
   logic                          byp_ff;

   logic [ROW_W-1:0]        hist_mem [CHAN_COUNT];
   logic [ROW_W-1:0]        row_ff;
   logic                    rowv_ff;
   logic [ROW_W-1:0]        hist_row;
   logic [ROW_W-1:0]        new_row;
   logic [CHAN_COUNT-1:0]   row_valid_ff;
   logic [CH_W-1:0]         ch_idx;

   logic                          rsp_tvalid_ff;
   logic [TDATA_W-1:0]            rsp_tdata_ff;
   logic [CH_FIELD_W-1:0]         rsp_tuser_ff;
   logic                          rsp_tlast_ff;

   logic signed [COEF_W-1:0]      coef_mux;
   logic signed [SAMPLE_BITS-1:0] opd_mux;
   logic signed [SAMPLE_BITS-1:0] sat_out;
   logic signed [SAMPLE_BITS-1:0] result;

   logic req_accept, bypass_now, cfg_hit, rsp_free, emit, hist_we;

   assign uc         = ucode_rom(pc_ff);
   assign req_tready = (uc.seq == SEQ_ACCEPT);
   assign req_accept = req_tvalid && req_tready;
   assign bypass_now = !enable_ff || (32'(req_tuser) >= CHAN_COUNT);
   assign csr_ready  = 1'b1;
   assign cfg_hit    = csr_valid && csr_ready && (csr_index <= CSR_ENABLE);
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;
   assign emit       = (uc.seq == SEQ_EMIT) && rsp_free;
   assign hist_we    = emit && !byp_ff;
   assign ch_idx     = CH_W'(ch_ff);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hp_b0_ff  <= HP_B0_RESET;
         hp_a1_ff  <= HP_A1_RESET;
         hp_a2_ff  <= HP_A2_RESET;
         lp_b0_ff  <= LP_B0_RESET;
         lp_a1_ff  <= LP_A1_RESET;
         lp_a2_ff  <= LP_A2_RESET;
         enable_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_idx_type'(csr_index))
            CSR_HP_B0:  hp_b0_ff  <= csr_data;
            CSR_HP_A1:  hp_a1_ff  <= csr_data;
            CSR_HP_A2:  hp_a2_ff  <= csr_data;
            CSR_LP_B0:  lp_b0_ff  <= csr_data;
            CSR_LP_A1:  lp_a1_ff  <= csr_data;
            CSR_LP_A2:  lp_a2_ff  <= csr_data;
            CSR_ENABLE: enable_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Step counter with conditional jumps
   always_comb begin
      pc_in = pc_ff;
      unique case (uc.seq)
         SEQ_ACCEPT: begin
            if (req_accept) begin
               pc_in = bypass_now ? uc.jmp : pc_ff + 1'b1;
            end
         end
         SEQ_EMIT: begin
            if (rsp_free) begin
               pc_in = uc.jmp;
            end
         end
         default: pc_in = pc_ff + 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= IDLE_STEP;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // Request capture and high-pass output latch
   always_ff @(posedge clock) begin
      if (req_accept) begin
         ch_ff     <= req_tuser;
         sample_ff <= req_tdata[SAMPLE_BITS-1:0];
         last_ff   <= req_tlast;
         byp_ff    <= bypass_now;
      end
      if (uc.mid_ld) begin
         mid_ff <= sat_out;
      end
   end

   // History memory: one row per channel, high-pass x1 x2 y1 y2 then low-pass
   always_ff @(posedge clock) begin
      if (uc.mem_rd) begin
         row_ff  <= hist_mem[ch_idx];
         rowv_ff <= row_valid_ff[ch_idx];
      end
      if (hist_we) begin
         hist_mem[ch_idx] <= new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_hit) begin
         row_valid_ff <= '0;
      end else if (hist_we) begin
         row_valid_ff[ch_idx] <= 1'b1;
      end
   end

   assign hist_row = rowv_ff ? row_ff : '0;
   assign new_row  = {hist_row[6*SAMPLE_BITS +: SAMPLE_BITS], sat_out,
                      hist_row[4*SAMPLE_BITS +: SAMPLE_BITS], mid_ff,
                      hist_row[2*SAMPLE_BITS +: SAMPLE_BITS], mid_ff,
                      hist_row[0*SAMPLE_BITS +: SAMPLE_BITS], sample_ff};

   // Operand and coefficient select
   always_comb begin
      unique case (uc.opd)
         OPD_SAMPLE: opd_mux = sample_ff;
         OPD_MID:    opd_mux = mid_ff;
         OPD_H0:     opd_mux = hist_row[0*SAMPLE_BITS +: SAMPLE_BITS];
         OPD_H1:     opd_mux = hist_row[1*SAMPLE_BITS +: SAMPLE_BITS];
         OPD_H2:     opd_mux = hist_row[2*SAMPLE_BITS +: SAMPLE_BITS];
         OPD_H3:     opd_mux = hist_row[3*SAMPLE_BITS +: SAMPLE_BITS];
         OPD_H4:     opd_mux = hist_row[4*SAMPLE_BITS +: SAMPLE_BITS];
         OPD_H5:     opd_mux = hist_row[5*SAMPLE_BITS +: SAMPLE_BITS];
         OPD_H6:     opd_mux = hist_row[6*SAMPLE_BITS +: SAMPLE_BITS];
         OPD_H7:     opd_mux = hist_row[7*SAMPLE_BITS +: SAMPLE_BITS];
         default:    opd_mux = '0;
      endcase
   end

   always_comb begin
      unique case (uc.coef)
         CF_HP_B0: coef_mux = hp_b0_ff;
         CF_HP_A1: coef_mux = hp_a1_ff;
         CF_HP_A2: coef_mux = hp_a2_ff;
         CF_LP_B0: coef_mux = lp_b0_ff;
         CF_LP_A1: coef_mux = lp_a1_ff;
         CF_LP_A2: coef_mux = lp_a2_ff;
         default:  coef_mux = '0;
      endcase
   end

   mbqbp_mac #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mac (
      .clock   (clock),
      .ctrl    (uc.mac),
      .coef    (coef_mux),
      .operand (opd_mux),
      .sat_out (sat_out)
   );

   // Response register
   assign result = byp_ff ? sample_ff : sat_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (emit) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_tdata_ff <= TDATA_W'(result[SAMPLE_BITS-1:0]);
         rsp_tuser_ff <= ch_ff;
         rsp_tlast_ff <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   a_cfg_clears: assert property (@(posedge clock) disable iff (reset)
      cfg_hit |=> (row_valid_ff == '0))
      else $error("config write did not clear history");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == IDLE_STEP) && !req_accept |=> (pc_ff == IDLE_STEP))
      else $error("sequencer left idle without a request");

   a_bypass_jump: assert property (@(posedge clock) disable iff (reset)
      req_accept && bypass_now |=> (pc_ff == FINAL_STEP))
      else $error("bypassed request did not go to the final step");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> ($past(pc_ff) == FINAL_STEP))
      else $error("response loaded outside the final step");

   a_row_marked: assert property (@(posedge clock) disable iff (reset)
      hist_we |=> row_valid_ff[$past(ch_idx)])
      else $error("written history row not marked valid");

endmodule

`default_nettype wire

// ===== tb/multichannel_biquad_bandpass_tb.sv =====
// Self-checking testbench for multichannel_biquad_bandpass: random stream traffic,
// coefficient and enable writes, per-channel two-stage biquad prediction.
// Depends on mbqbp_pkg and the multichannel_biquad_bandpass RTL only.
`default_nettype none

module multichannel_biquad_bandpass_tb
   import mbqbp_pkg::*;
();

   localparam int NUM_CH      = 16;
   localparam int SAMPLE_BITS = 24;
   localparam int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int PHASE_ITEMS = 205;
   localparam int HOLD_CYCLES = 400;
   localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_IDX = 3'd7;

   typedef struct {
      logic [CH_FIELD_W-1:0]  chan;
      logic [SAMPLE_BITS-1:0] pcm;
      logic                   is_last;
   } audio_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [TDATA_W-1:0]     req_tdata  = '0;  // [23:0] sample_in
   logic [CH_FIELD_W-1:0]  req_tuser  = '0;  // [3:0] channel
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [TDATA_W-1:0]     rsp_tdata;        // [23:0] sample_out
   logic [CH_FIELD_W-1:0]  rsp_tuser;        // [3:0] channel_out
   logic                   rsp_tlast;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [COEF_W-1:0]      csr_data   = '0;

   multichannel_biquad_bandpass #(
      .CHAN_COUNT  (NUM_CH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   logic signed [COEF_W-1:0] hp_b0 = HP_B0_RESET;
   logic signed [COEF_W-1:0] hp_a1 = HP_A1_RESET;
   logic signed [COEF_W-1:0] hp_a2 = HP_A2_RESET;
   logic signed [COEF_W-1:0] lp_b0 = LP_B0_RESET;
   logic signed [COEF_W-1:0] lp_a1 = LP_A1_RESET;
   logic signed [COEF_W-1:0] lp_a2 = LP_A2_RESET;
   logic                     filter_on = 1'b0;
   // per channel: x1, x2, y1, y2
   longint hp_hist [NUM_CH][4];
   longint lp_hist [NUM_CH][4];

   audio_word_type pending_samples[$];
   audio_word_type expected_outputs[$];

   bit gaps_on         = 1'b1;
   int mismatches      = 0;
   int outputs_seen    = 0;
   int hold_left       = 0;
   int filter_settings = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic void clear_history();
      for (int c = 0; c < NUM_CH; c++) begin
         for (int k = 0; k < 4; k++) begin
            hp_hist[c][k] = 0;
            lp_hist[c][k] = 0;
         end
      end
   endfunction

   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [COEF_W-1:0] value);
      case (idx)
         CSR_HP_B0:  hp_b0 = value;
         CSR_HP_A1:  hp_a1 = value;
         CSR_HP_A2:  hp_a2 = value;
         CSR_LP_B0:  lp_b0 = value;
         CSR_LP_A1:  lp_a1 = value;
         CSR_LP_A2:  lp_a2 = value;
         CSR_ENABLE: filter_on = value[0];
         default:    return;
      endcase
      clear_history();
   endfunction

   function automatic longint biquad_out(longint b0, longint b1_sign, longint a1, longint a2,
                                         longint x, longint x1, longint x2,
                                         longint y1, longint y2);
      longint acc;
      acc = b0 * x + b1_sign * 2 * (b0 * x1) + b0 * x2 + a1 * y1 + a2 * y2;
      acc = acc >>> COEF_SHIFT;
      if (acc > SAMPLE_MAX) return SAMPLE_MAX;
      if (acc < SAMPLE_MIN) return SAMPLE_MIN;
      return acc;
   endfunction

   function automatic audio_word_type filter_sample(audio_word_type in_word);
      audio_word_type res;
      longint x, mid, y;
      int ch;
      res = in_word;
      if (filter_on && in_word.chan < NUM_CH) begin
         ch  = in_word.chan;
         x   = longint'($signed(in_word.pcm));
         mid = biquad_out(hp_b0, -1, hp_a1, hp_a2, x,
                          hp_hist[ch][0], hp_hist[ch][1], hp_hist[ch][2], hp_hist[ch][3]);
         hp_hist[ch][1] = hp_hist[ch][0];
         hp_hist[ch][0] = x;
         hp_hist[ch][3] = hp_hist[ch][2];
         hp_hist[ch][2] = mid;
         y   = biquad_out(lp_b0, 1, lp_a1, lp_a2, mid,
                          lp_hist[ch][0], lp_hist[ch][1], lp_hist[ch][2], lp_hist[ch][3]);
         lp_hist[ch][1] = lp_hist[ch][0];
         lp_hist[ch][0] = mid;
         lp_hist[ch][3] = lp_hist[ch][2];
         lp_hist[ch][2] = y;
         res.pcm = y[SAMPLE_BITS-1:0];
      end
      return res;
   endfunction

   always @(posedge clock) begin : driver
      audio_word_type head;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_outputs.push_back(filter_sample(pending_samples.pop_front()));
         if (!req_tvalid || req_tready) begin
            if (pending_samples.size() > 0 && (!gaps_on || $urandom_range(99) >= 19)) begin
               head = pending_samples[0];
               req_tvalid <= 1'b1;
               req_tdata  <= TDATA_W'(head.pcm);
               req_tuser  <= head.chan;
               req_tlast  <= head.is_last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      audio_word_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.chan    = rsp_tuser;
            got.pcm     = rsp_tdata[SAMPLE_BITS-1:0];
            got.is_last = rsp_tlast;
            outputs_seen++;
            if (expected_outputs.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response %0d: ch %0d sample %0d last %0b",
                           outputs_seen, got.chan, $signed(got.pcm), got.is_last);
            end else begin
               want = expected_outputs.pop_front();
               if (got.chan !== want.chan || got.pcm !== want.pcm
                   || got.is_last !== want.is_last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"response %0d mismatch: expected ch %0d sample %0d last %0b,",
                               " got ch %0d sample %0d last %0b"},
                              outputs_seen, want.chan, $signed(want.pcm), want.is_last,
                              got.chan, $signed(got.pcm), got.is_last);
               end
            end
            if (outputs_seen == 300 || outputs_seen == 1000)
               hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (gaps_on) begin
            rsp_tready <= ($urandom_range(99) >= 19);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      apply_csr(idx, value);
   endtask

   task automatic set_filter(input logic [COEF_W-1:0] hb0, ha1, ha2, lb0, la1, la2,
                             input logic en);
      write_csr(CSR_HP_B0, hb0);
      write_csr(CSR_HP_A1, ha1);
      write_csr(CSR_HP_A2, ha2);
      write_csr(CSR_LP_B0, lb0);
      write_csr(CSR_LP_A1, la1);
      write_csr(CSR_LP_A2, la2);
      write_csr(CSR_ENABLE, COEF_W'(en));
      filter_settings++;
   endtask

   task automatic wait_drained();
      while (pending_samples.size() != 0 || expected_outputs.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic queue_sample(input int ch, input int pcm, input logic is_last);
      audio_word_type w;
      w.chan    = ch[CH_FIELD_W-1:0];
      w.pcm     = pcm[SAMPLE_BITS-1:0];
      w.is_last = is_last;
      pending_samples.push_back(w);
   endtask

   initial begin : stimulus
      int ch, pcm, pick;
      logic [COEF_W-1:0] cf [6];
      logic en;
      clear_history();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // bypass after reset
      queue_sample(0, -8388608, 1'b0);
      queue_sample(15, 8388607, 1'b1);
      queue_sample(5, 0, 1'b0);
      queue_sample(10, -1, 1'b1);
      wait_drained();

      // reset coefficients, filtering on: steps and sign flips on channels 2 and 15
      write_csr(CSR_ENABLE, COEF_W'(1));
      queue_sample(2, 8388607, 1'b0);
      queue_sample(2, 8388607, 1'b0);
      queue_sample(2, 8388607, 1'b0);
      queue_sample(2, -8388608, 1'b0);
      queue_sample(2, -8388608, 1'b1);
      queue_sample(15, -1, 1'b0);
      queue_sample(15, 1, 1'b1);
      wait_drained();

      // write to an index past the register list: history must survive
      write_csr(CSR_UNUSED_IDX, '1);
      queue_sample(2, 8388607, 1'b0);
      queue_sample(2, 0, 1'b0);
      queue_sample(15, 0, 1'b1);
      wait_drained();

      // saturating coefficients
      set_filter(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
      queue_sample(7, 8388607, 1'b0);
      queue_sample(7, -8388608, 1'b0);
      queue_sample(7, 8388607, 1'b0);
      queue_sample(7, 100, 1'b1);
      queue_sample(0, -8388608, 1'b0);
      queue_sample(0, -100, 1'b1);
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         en = 1'b1;
         case (p)
            0, 1: begin
               cf = '{HP_B0_RESET, HP_A1_RESET, HP_A2_RESET,
                      LP_B0_RESET, LP_A1_RESET, LP_A2_RESET};
            end
            2: cf = '{default: 32'h7FFF_FFFF};
            3: cf = '{default: 32'h8000_0000};
            4: begin
               for (int k = 0; k < 6; k++) cf[k] = $urandom;
               en = 1'b0;
            end
            5: for (int k = 0; k < 6; k++) cf[k] = $urandom;
            default: begin
               cf[0] = $urandom_range(32'h4000_0000, 32'h0010_0000);
               cf[1] = $urandom_range(32'h7FFF_0000, 32'h2000_0000);
               cf[2] = 32'd0 - $urandom_range(32'h4000_0000, 32'h0800_0000);
               cf[3] = $urandom_range(32'h2000_0000, 32'h0010_0000);
               cf[4] = $urandom_range(32'h6000_0000, 32'h1000_0000);
               cf[5] = 32'd0 - $urandom_range(32'h2000_0000, 32'h0400_0000);
            end
         endcase
         set_filter(cf[0], cf[1], cf[2], cf[3], cf[4], cf[5], en);
         gaps_on = (p != 1);
         ch = $urandom_range(NUM_CH - 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(1) == 0) ch = $urandom_range(NUM_CH - 1);
            pick = $urandom_range(99);
            if (pick < 60)
               pcm = $urandom;
            else if (pick < 85)
               pcm = int'($urandom_range(8191)) - 4096;
            else
               case ($urandom_range(3))
                  0: pcm = 8388607;
                  1: pcm = -8388608;
                  2: pcm = 0;
                  default: pcm = -1;
               endcase
            queue_sample(ch, pcm, $urandom_range(7) == 0);
         end
         wait_drained();
         gaps_on = 1'b1;
      end

      repeat (40) @(posedge clock);
      $display("Checked %0d responses across %0d filter settings, bypass included.",
               outputs_seen, filter_settings + 2);
      $display("Covered saturating coefficients, an unused register index and %0d-cycle stalls.",
               HOLD_CYCLES);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("timeout with %0d requests pending", pending_samples.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/mbqbp_pkg.sv
hw/rtl/mbqbp_mac.sv
hw/rtl/multichannel_biquad_bandpass.sv
tb/multichannel_biquad_bandpass_tb.sv
